>>> design/text_console_cursor_engine_core_defines.svh
// assertion macros for the checker file
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_CORE_DEFINES_SVH

// checked on every clock edge outside reset
`define TCCE_ASSERT_SYNC(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define TCCE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> design/tcce_pkg.sv
`default_nettype none
package tcce_pkg;

    localparam int COLS      = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 4;
    localparam int CELLS     = ROWS * COLS;

    // fixed field widths of the stream items
    localparam int MODE_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int HEX_W   = 32;
    localparam int NDIG_W  = 4;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CELL_W  = 16;

    // internal widths
    localparam int CUR_ROW_W = $clog2(ROWS + 1);
    localparam int CUR_COL_W = $clog2(COLS);
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int WALK_W    = $clog2(CELLS + 1);
    localparam int CNT_W     = 4;

    localparam logic [MODE_W-1:0] MODE_PUT_CHAR   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUT_HEX    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BACKSPACE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET_CURSOR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ_CELL  = 3'd5;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_TAB        = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'd32;
    localparam logic [CHAR_W-1:0] HEX_DIGIT_BASE  = 8'd48;
    localparam logic [CHAR_W-1:0] HEX_ALPHA_BASE  = 8'd55;
    localparam logic [CHAR_W-1:0] RESET_ATTR      = 8'd15;

    // input tdata layout, lowest field last
    typedef struct packed {
        logic [COL_W-1:0]  col_index;
        logic [ROW_W-1:0]  row_index;
        logic [NDIG_W-1:0] hex_digits;
        logic [HEX_W-1:0]  hex_value;
        logic [CHAR_W-1:0] char_code;
    } t_in_data;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        t_in_data          data;
    } t_cmd;

    typedef struct packed {
        logic start;
        t_cmd cmd;
    } t_seq_req;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_seq_stat;

    // output tdata layout, lowest field last
    typedef struct packed {
        logic [2:0]        pad;
        logic              overflow;
        logic [CHAR_W-1:0] read_attr;
        logic [CHAR_W-1:0] read_char;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
    } t_out_item;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CELL_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_mem_req;

endpackage
`default_nettype wire

>>> design/tcce_ram.sv
`default_nettype none
module tcce_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output      logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> design/tcce_seq.sv
`default_nettype none
module tcce_seq (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire tcce_pkg::t_seq_req         i_req,
    input  wire logic [tcce_pkg::CHAR_W-1:0] i_attr,
    input  wire logic                       i_res_ack,
    output      tcce_pkg::t_seq_stat        o_stat,
    output      tcce_pkg::t_out_item        o_res,
    output      tcce_pkg::t_mem_req         o_mem,
    input  wire logic [tcce_pkg::CELL_W-1:0] i_mem_rd_data
);

    import tcce_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_EXEC, S_WRITE, S_BACK, S_SCROLL, S_CLEAR, S_READ, S_RESP
    } t_state;

    typedef enum logic [1:0] {
        KIND_SPACE, KIND_CHAR, KIND_HEX
    } t_kind;

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    t_kind                 r_kind, n_kind;
    logic [CUR_ROW_W-1:0]  r_row, n_row;
    logic [CUR_COL_W-1:0]  r_col, n_col;
    logic [WALK_W-1:0]     r_walk, n_walk;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [HEX_W-1:0]      r_hex, n_hex;
    logic                  r_ovf, n_ovf;
    logic [CHAR_W-1:0]     r_rd_char, n_rd_char;
    logic [CHAR_W-1:0]     r_rd_attr, n_rd_attr;
    logic                  r_mv_pend, n_mv_pend;
    logic [ADDR_W-1:0]     r_mv_dst, n_mv_dst;

    logic [ROW_W-1:0]      row_clamp;
    logic [COL_W-1:0]      col_clamp;
    logic [NDIG_W-1:0]     ndig;
    logic [2:0]            skip_dig;
    logic [ADDR_W-1:0]     cur_addr;
    logic                  past_end;
    logic [CHAR_W-1:0]     wr_char;
    logic [3:0]            nib;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [CUR_ROW_W-1:0] row,
                                                    input logic [CUR_COL_W-1:0] col);
        cell_addr = ADDR_W'(32'(row) * 32'(COLS) + 32'(col));
    endfunction

    always_comb begin
        row_clamp = (32'(r_cmd.data.row_index) > ROWS - 1) ? ROW_W'(ROWS - 1)
                                                            : r_cmd.data.row_index;
        col_clamp = (32'(r_cmd.data.col_index) > COLS - 1) ? COL_W'(COLS - 1)
                                                            : r_cmd.data.col_index;
        ndig = r_cmd.data.hex_digits;
        if (ndig == '0) begin
            ndig = NDIG_W'(1);
        end else if (ndig > NDIG_W'(8)) begin
            ndig = NDIG_W'(8);
        end
        skip_dig = 3'(NDIG_W'(8) - ndig);
        cur_addr = cell_addr(r_row, r_col);
        past_end = (r_row == CUR_ROW_W'(ROWS));
        nib      = r_hex[HEX_W-1 -: 4];
        case (r_kind)
            KIND_CHAR: wr_char = r_cmd.data.char_code;
            KIND_HEX:  wr_char = (nib < 4'd10) ? HEX_DIGIT_BASE + CHAR_W'(nib)
                                               : HEX_ALPHA_BASE + CHAR_W'(nib);
            default:   wr_char = CHAR_SPACE;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_kind    = r_kind;
        n_row     = r_row;
        n_col     = r_col;
        n_walk    = r_walk;
        n_cnt     = r_cnt;
        n_hex     = r_hex;
        n_ovf     = r_ovf;
        n_rd_char = r_rd_char;
        n_rd_attr = r_rd_attr;
        n_mv_pend = 1'b0;
        n_mv_dst  = r_mv_dst;
        o_mem     = '0;
        o_mem.wr_data = {i_attr, CHAR_SPACE};

        // second half of a scroll move: write back what was read last cycle
        if (r_mv_pend) begin
            o_mem.wr_en   = 1'b1;
            o_mem.wr_addr = r_mv_dst;
            o_mem.wr_data = i_mem_rd_data;
        end

        unique case (r_state)
            S_INIT: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_walk[ADDR_W-1:0];
                o_mem.wr_data = {RESET_ATTR, CHAR_SPACE};
                if (r_walk == WALK_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_walk = r_walk + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_req.start) begin
                    n_cmd   = i_req.cmd;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_ovf     = 1'b0;
                n_rd_char = '0;
                n_rd_attr = '0;
                n_state   = S_RESP;
                unique case (r_cmd.mode)
                    MODE_PUT_CHAR: begin
                        if (r_cmd.data.char_code == CHAR_NEWLINE) begin
                            n_col = '0;
                            if (r_row >= CUR_ROW_W'(ROWS - 1)) begin
                                n_row   = CUR_ROW_W'(ROWS - 1);
                                n_walk  = WALK_W'(COLS);
                                n_state = S_SCROLL;
                            end else begin
                                n_row = r_row + 1'b1;
                            end
                        end else if (r_cmd.data.char_code == CHAR_TAB) begin
                            n_cnt   = CNT_W'(TAB_WIDTH);
                            n_kind  = KIND_SPACE;
                            n_state = S_WRITE;
                        end else begin
                            n_cnt   = CNT_W'(1);
                            n_kind  = KIND_CHAR;
                            n_state = S_WRITE;
                        end
                    end
                    MODE_PUT_HEX: begin
                        n_cnt   = CNT_W'(ndig);
                        n_kind  = KIND_HEX;
                        // left-align the first digit to print
                        n_hex   = r_cmd.data.hex_value << {skip_dig, 2'b00};
                        n_state = S_WRITE;
                    end
                    MODE_BACKSPACE: begin
                        if (r_row != '0 || r_col != '0) begin
                            if (r_col == '0) begin
                                n_row = r_row - 1'b1;
                                n_col = CUR_COL_W'(COLS - 1);
                            end else begin
                                n_col = r_col - 1'b1;
                            end
                            n_state = S_BACK;
                        end
                    end
                    MODE_SET_CURSOR: begin
                        n_row = CUR_ROW_W'(row_clamp);
                        n_col = CUR_COL_W'(col_clamp);
                    end
                    MODE_CLEAR: begin
                        n_row   = '0;
                        n_col   = '0;
                        n_walk  = '0;
                        n_state = S_CLEAR;
                    end
                    MODE_READ_CELL: begin
                        o_mem.rd_en   = 1'b1;
                        o_mem.rd_addr = cell_addr(CUR_ROW_W'(row_clamp),
                                                  CUR_COL_W'(col_clamp));
                        n_state       = S_READ;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_WRITE: begin
                if (past_end) begin
                    n_ovf = 1'b1;
                end else begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = cur_addr;
                    o_mem.wr_data = {i_attr, wr_char};
                    if (r_col == CUR_COL_W'(COLS - 1)) begin
                        n_row = r_row + 1'b1;
                        n_col = '0;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
                n_hex = r_hex << 4;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_RESP;
                end
            end
            S_BACK: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = cur_addr;
                o_mem.wr_data = {i_attr, CHAR_SPACE};
                n_state       = S_RESP;
            end
            S_SCROLL: begin
                if (r_walk == WALK_W'(CELLS)) begin
                    n_state = S_RESP;
                end else begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr = r_walk[ADDR_W-1:0];
                    n_mv_pend     = 1'b1;
                    n_mv_dst      = ADDR_W'(r_walk - WALK_W'(COLS));
                    n_walk        = r_walk + 1'b1;
                end
            end
            S_CLEAR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_walk[ADDR_W-1:0];
                o_mem.wr_data = {i_attr, CHAR_SPACE};
                if (r_walk == WALK_W'(CELLS - 1)) begin
                    n_state = S_RESP;
                end else begin
                    n_walk = r_walk + 1'b1;
                end
            end
            S_READ: begin
                n_rd_char = i_mem_rd_data[CHAR_W-1:0];
                n_rd_attr = i_mem_rd_data[CELL_W-1:CHAR_W];
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (i_res_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_row     <= '0;
            r_col     <= '0;
            r_walk    <= '0;
            r_mv_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_col     <= n_col;
            r_walk    <= n_walk;
            r_mv_pend <= n_mv_pend;
        end
        r_cmd     <= n_cmd;
        r_kind    <= n_kind;
        r_cnt     <= n_cnt;
        r_hex     <= n_hex;
        r_ovf     <= n_ovf;
        r_rd_char <= n_rd_char;
        r_rd_attr <= n_rd_attr;
        r_mv_dst  <= n_mv_dst;
    end

    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.res_valid = (r_state == S_RESP);

    assign o_res.pad        = '0;
    assign o_res.overflow   = r_ovf;
    assign o_res.read_attr  = r_rd_attr;
    assign o_res.read_char  = r_rd_char;
    assign o_res.cursor_col = COL_W'(r_col);
    assign o_res.cursor_row = ROW_W'(r_row);

endmodule
`default_nettype wire

>>> design/text_console_cursor_engine_core.sv
// channel   dir  handshake              payload
// s         in   i_s_tvalid/o_s_tready  i_s_tuser mode, i_s_tdata command fields
// m         out  o_m_tvalid/i_m_tready  o_m_tdata cursor, read cell, overflow
// cfg       in   i_cfg_wr_en            i_cfg_wr_data text attribute
//
// one command at a time; a transfer is decoded in the cycle after it is taken and
// its result is ready once its memory accesses are done. cell writes go one per
// cycle through the single write port of the cell memory. after reset a clearing
// pass fills the memory with blanks, with o_s_tready low. a new command is taken
// while the last result still waits in the output register; a command finishing
// before that register frees holds.
`default_nettype none
module text_console_cursor_engine_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    output      logic                         o_s_tready,
    // char_code, hex_value, hex_digits, row_index, col_index
    input  wire logic [55:0]                  i_s_tdata,
    // mode
    input  wire logic [tcce_pkg::MODE_W-1:0]  i_s_tuser,
    output      logic                         o_m_tvalid,
    input  wire logic                         i_m_tready,
    // cursor_row, cursor_col, read_char, read_attr, overflow, zero fill
    output      logic [31:0]                  o_m_tdata,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [tcce_pkg::CHAR_W-1:0]  i_cfg_wr_data
);

    import tcce_pkg::*;

    t_seq_req           seq_req;
    t_seq_stat          seq_stat;
    t_out_item          seq_res;
    t_mem_req           mem_req;
    logic [CELL_W-1:0]  mem_rd_data;
    logic               res_load;

    logic [CHAR_W-1:0]  r_attr;
    logic               r_m_valid;
    t_out_item          r_m_data;

    assign o_s_tready        = seq_stat.idle;
    assign seq_req.start     = i_s_tvalid && o_s_tready;
    assign seq_req.cmd.mode  = i_s_tuser;
    assign seq_req.cmd.data  = t_in_data'(i_s_tdata);

    // output register frees the sequencer as soon as a result is parked
    assign res_load = seq_stat.res_valid && (!r_m_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr    <= RESET_ATTR;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_attr <= i_cfg_wr_data;
            end
            if (res_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        if (res_load) begin
            r_m_data <= seq_res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    tcce_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (seq_req),
        .i_attr        (r_attr),
        .i_res_ack     (res_load),
        .o_stat        (seq_stat),
        .o_res         (seq_res),
        .o_mem         (mem_req),
        .i_mem_rd_data (mem_rd_data)
    );

    tcce_ram #(
        .DATA_W (CELL_W),
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_req.wr_en),
        .i_wr_addr (mem_req.wr_addr),
        .i_wr_data (mem_req.wr_data),
        .i_rd_en   (mem_req.rd_en),
        .i_rd_addr (mem_req.rd_addr),
        .o_rd_data (mem_rd_data)
    );

endmodule
`default_nettype wire

>>> design/tcce_checker.sv
`default_nettype none
`include "text_console_cursor_engine_core_defines.svh"
module tcce_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata
);

    import tcce_pkg::*;

    t_out_item out_item;

    assign out_item = t_out_item'(o_m_tdata);

    `TCCE_ASSERT_SYNC(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "result changed while stalled")
    `TCCE_ASSERT_SYNC(a_col_range, o_m_tvalid |-> 32'(out_item.cursor_col) < COLS, "cursor column out of range")
    `TCCE_ASSERT_SYNC(a_ovf_past_end, o_m_tvalid && out_item.overflow |-> out_item.cursor_row == ROW_W'(ROWS) && out_item.cursor_col == '0, "overflow without full screen")
    `TCCE_ASSERT_SYNC(a_one_cmd, i_s_tvalid && o_s_tready |=> !o_s_tready, "second command taken while busy")
    `TCCE_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_m_tvalid && !o_s_tready, "handshake active after reset")

endmodule

bind text_console_cursor_engine_core tcce_checker u_checker (.*);
`default_nettype wire

>>> bench/console_check.sv
`timescale 1ns / 1ps
module console_check (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    input  wire logic                        i_s_tready,
    input  wire logic [55:0]                 i_s_tdata,
    input  wire logic [tcce_pkg::MODE_W-1:0] i_s_tuser,
    input  wire logic                        i_m_tvalid,
    input  wire logic                        i_m_tready,
    input  wire logic [31:0]                 i_m_tdata,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [tcce_pkg::CHAR_W-1:0] i_cfg_wr_data,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked,
    output int                               o_overflows,
    output int                               o_scrolls
);
    import tcce_pkg::*;

    localparam int PRINT_CAP = 50;

    // shadow copy of the screen: attribute in the upper byte, character in the lower
    logic [CELL_W-1:0] screen [CELLS];
    int unsigned       cur_pos;
    logic [CHAR_W-1:0] attr_reg;
    t_out_item         status_q [$];
    t_out_item         got;
    t_out_item         want;
    int                k;

    task automatic flag_mismatch(input string what, input int got_v, input int want_v);
        o_fail_count++;
        if (o_fail_count <= PRINT_CAP) begin
            $display("console_check: result %0d %s: got %0d, expected %0d",
                     o_checked, what, got_v, want_v);
        end
    endtask

    // returns 1 when the character is lost past the last cell
    function automatic bit put_glyph(input logic [CHAR_W-1:0] ch);
        if (cur_pos >= CELLS) return 1'b1;
        screen[cur_pos] = {attr_reg, ch};
        cur_pos++;
        return 1'b0;
    endfunction

    function automatic void line_feed();
        int i;
        if (cur_pos / COLS >= ROWS - 1) begin
            // rows move up one, the last row keeps its old contents
            for (i = COLS; i < CELLS; i++) screen[i - COLS] = screen[i];
            cur_pos = (ROWS - 1) * COLS;
            o_scrolls++;
        end else begin
            cur_pos = (cur_pos / COLS + 1) * COLS;
        end
    endfunction

    function automatic t_out_item console_step(input logic [MODE_W-1:0] mode, input t_in_data d);
        t_out_item   r;
        int unsigned row;
        int unsigned col;
        int unsigned ndig;
        int unsigned nib;
        int          i;
        bit          lost;
        logic [CELL_W-1:0] cell_word;
        r    = '0;
        lost = 1'b0;
        row  = (d.row_index > ROWS - 1) ? ROWS - 1 : d.row_index;
        col  = (d.col_index > COLS - 1) ? COLS - 1 : d.col_index;
        case (mode)
            MODE_PUT_CHAR: begin
                if (d.char_code == CHAR_NEWLINE) begin
                    line_feed();
                end else if (d.char_code == CHAR_TAB) begin
                    for (i = 0; i < TAB_WIDTH; i++) lost = put_glyph(CHAR_SPACE) | lost;
                end else begin
                    lost = put_glyph(d.char_code);
                end
            end
            MODE_PUT_HEX: begin
                ndig = d.hex_digits;
                if (ndig < 1) ndig = 1;
                if (ndig > 8) ndig = 8;
                for (i = ndig; i > 0; i--) begin
                    nib  = (d.hex_value >> (4 * (i - 1))) & 32'hF;
                    lost = put_glyph(nib < 10 ? CHAR_W'(HEX_DIGIT_BASE + nib)
                                              : CHAR_W'(HEX_ALPHA_BASE + nib)) | lost;
                end
            end
            MODE_BACKSPACE: begin
                if (cur_pos != 0) begin
                    cur_pos--;
                    void'(put_glyph(CHAR_SPACE));
                    cur_pos--;
                end
            end
            MODE_SET_CURSOR: begin
                cur_pos = row * COLS + col;
            end
            MODE_CLEAR: begin
                for (i = 0; i < CELLS; i++) screen[i] = {attr_reg, CHAR_SPACE};
                cur_pos = 0;
            end
            MODE_READ_CELL: begin
                cell_word   = screen[row * COLS + col];
                r.read_char = cell_word[CHAR_W-1:0];
                r.read_attr = cell_word[CELL_W-1:CHAR_W];
            end
            default: begin
            end
        endcase
        r.cursor_row = ROW_W'(cur_pos / COLS);
        r.cursor_col = COL_W'(cur_pos % COLS);
        r.overflow   = lost;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (k = 0; k < CELLS; k++) screen[k] = {RESET_ATTR, CHAR_SPACE};
            cur_pos  = 0;
            attr_reg = RESET_ATTR;
            status_q.delete();
        end else begin
            if (i_cfg_wr_en) attr_reg = i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready) begin
                status_q.push_back(console_step(i_s_tuser, t_in_data'(i_s_tdata)));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_out_item'(i_m_tdata);
                if (status_q.size() == 0) begin
                    flag_mismatch("transfer with nothing outstanding, tdata", i_m_tdata, 0);
                end else begin
                    want = status_q.pop_front();
                    if (got.cursor_row != want.cursor_row)
                        flag_mismatch("cursor_row", got.cursor_row, want.cursor_row);
                    if (got.cursor_col != want.cursor_col)
                        flag_mismatch("cursor_col", got.cursor_col, want.cursor_col);
                    if (got.read_char != want.read_char)
                        flag_mismatch("read_char", got.read_char, want.read_char);
                    if (got.read_attr != want.read_attr)
                        flag_mismatch("read_attr", got.read_attr, want.read_attr);
                    if (got.overflow != want.overflow)
                        flag_mismatch("overflow", got.overflow, want.overflow);
                    if (want.overflow) o_overflows++;
                end
                o_checked++;
            end
        end
        o_pending = status_q.size();
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import tcce_pkg::*;

    // modes the block decodes as no operation
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    localparam int RANDOM_PER_PHASE = 405;
    localparam int SQUEEZE_CYCLES   = 400;
    localparam int DRAIN_LIMIT      = 100000;
    localparam int TAIL_CYCLES      = 100;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic [55:0]         s_tdata     = '0;
    logic [MODE_W-1:0]   s_tuser     = '0;
    logic                m_tready    = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [CHAR_W-1:0]   cfg_wr_data = '0;
    logic                s_tready;
    logic                m_tvalid;
    logic [31:0]         m_tdata;

    int fail_cnt;
    int pend_cnt;
    int checked_cnt;
    int ovf_cnt;
    int scroll_cnt;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit squeeze_go     = 1'b0;
    int n_sent         = 0;
    int n_directed     = 0;
    int n_loads        = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    text_console_cursor_engine_core uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .o_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .o_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .o_m_tdata    (m_tdata),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    console_check u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .o_fail_count (fail_cnt),
        .o_pending    (pend_cnt),
        .o_checked    (checked_cnt),
        .o_overflows  (ovf_cnt),
        .o_scrolls    (scroll_cnt)
    );

    function automatic t_in_data cmd_fields(input logic [CHAR_W-1:0] ch,
                                            input logic [HEX_W-1:0] hv,
                                            input logic [NDIG_W-1:0] nd,
                                            input logic [ROW_W-1:0] row,
                                            input logic [COL_W-1:0] col);
        t_in_data f;
        f.char_code  = ch;
        f.hex_value  = hv;
        f.hex_digits = nd;
        f.row_index  = row;
        f.col_index  = col;
        return f;
    endfunction

    function automatic t_in_data noise_fields();
        return cmd_fields(CHAR_W'($urandom), $urandom, NDIG_W'($urandom),
                          ROW_W'($urandom), COL_W'($urandom));
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic push_cmd(input logic [MODE_W-1:0] mode, input t_in_data f);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= f;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        n_sent++;
    endtask

    task automatic settle();
        int waited;
        waited   = 0;
        s_tvalid <= 1'b0;
        while (pend_cnt != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
    endtask

    task automatic load_attribute(input logic [CHAR_W-1:0] value);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
        n_loads++;
    endtask

    task automatic run_random(input int quota);
        int       goal;
        int       pick;
        int       sel;
        t_in_data f;
        goal = n_sent + quota;
        while (n_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                // text with the odd newline and tab
                repeat ($urandom_range(40, 4)) begin
                    f   = noise_fields();
                    sel = $urandom_range(99);
                    if (sel < 5)       f.char_code = CHAR_NEWLINE;
                    else if (sel < 9)  f.char_code = CHAR_TAB;
                    else if (sel < 94) f.char_code = CHAR_W'($urandom_range(126, 32));
                    push_cmd(MODE_PUT_CHAR, f);
                end
            end else if (pick < 50) begin
                repeat ($urandom_range(6, 1)) begin
                    f = noise_fields();
                    if ($urandom_range(9) != 0) f.hex_digits = NDIG_W'($urandom_range(8, 1));
                    push_cmd(MODE_PUT_HEX, f);
                end
            end else if (pick < 60) begin
                // park near the last cell and write past it
                f = noise_fields();
                f.row_index = ROW_W'($urandom_range(31, ROWS - 1));
                f.col_index = COL_W'($urandom_range(COLS + 8, COLS - 9));
                push_cmd(MODE_SET_CURSOR, f);
                repeat ($urandom_range(12, 2)) begin
                    f = noise_fields();
                    f.hex_digits = NDIG_W'($urandom_range(8, 1));
                    push_cmd(($urandom_range(2) == 0) ? MODE_PUT_HEX : MODE_PUT_CHAR, f);
                end
                repeat ($urandom_range(3, 1)) begin
                    f = noise_fields();
                    f.row_index = ROW_W'($urandom_range(ROWS - 1, ROWS - 2));
                    push_cmd(MODE_READ_CELL, f);
                end
                f = noise_fields();
                if ($urandom_range(1) == 0) begin
                    push_cmd(MODE_BACKSPACE, f);
                end else begin
                    f.char_code = CHAR_NEWLINE;
                    push_cmd(MODE_PUT_CHAR, f);
                end
            end else if (pick < 75) begin
                repeat ($urandom_range(8, 1)) begin
                    f = noise_fields();
                    if ($urandom_range(7) != 0) begin
                        f.row_index = ROW_W'($urandom_range(ROWS - 1));
                        f.col_index = COL_W'($urandom_range(COLS - 1));
                    end
                    push_cmd(MODE_READ_CELL, f);
                end
            end else if (pick < 85) begin
                if ($urandom_range(2) == 0) begin
                    f = noise_fields();
                    f.row_index = '0;
                    f.col_index = COL_W'($urandom_range(3));
                    push_cmd(MODE_SET_CURSOR, f);
                end
                repeat ($urandom_range(6, 1)) push_cmd(MODE_BACKSPACE, noise_fields());
            end else if (pick < 92) begin
                push_cmd(MODE_SET_CURSOR, noise_fields());
            end else if (pick < 98) begin
                repeat ($urandom_range(4, 1)) push_cmd(MODE_W'($urandom), noise_fields());
            end else begin
                push_cmd(MODE_CLEAR, noise_fields());
            end
        end
    endtask

    // output side: one long hold-off at the start of the first random phase
    initial begin : receiver
        bit squeezed;
        squeezed = 1'b0;
        forever begin
            @(negedge clk);
            if (squeeze_go && !squeezed) begin
                squeezed = 1'b1;
                m_tready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(negedge clk);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #50ms;
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        logic [CHAR_W-1:0] attr_plan [4];
        int                idle_plan [4];
        int                stall_plan [4];
        int                ph;
        attr_plan  = '{8'hFF, 8'h00, CHAR_W'($urandom), 8'h5A};
        idle_plan  = '{0, 79, 0, 27};
        stall_plan = '{0, 0, 79, 27};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed commands under the reset attribute
        push_cmd(MODE_READ_CELL,  cmd_fields(8'h00, 32'h0, 4'h0, 5'd0, 7'd0));
        push_cmd(MODE_READ_CELL,  cmd_fields(8'h00, 32'h0, 4'h0, 5'd31, 7'd127));
        push_cmd(MODE_PUT_CHAR,   cmd_fields(8'hFF, 32'h0, 4'h0, 5'd0, 7'd0));
        push_cmd(MODE_PUT_CHAR,   cmd_fields(8'h00, 32'h0, 4'h0, 5'd0, 7'd0));
        push_cmd(MODE_PUT_CHAR,   cmd_fields(CHAR_TAB, 32'h0, 4'h0, 5'd0, 7'd0));
        push_cmd(MODE_PUT_HEX,    cmd_fields(8'h00, 32'hDEAD_BEEF, 4'd8, 5'd0, 7'd0));
        push_cmd(MODE_PUT_HEX,    cmd_fields(8'h00, 32'h0123_4567, 4'd0, 5'd0, 7'd0));
        push_cmd(MODE_PUT_HEX,    cmd_fields(8'h00, 32'hFEDC_BA98, 4'd15, 5'd0, 7'd0));
        push_cmd(MODE_PUT_HEX,    cmd_fields(8'h00, 32'h0, 4'd8, 5'd0, 7'd0));
        push_cmd(MODE_BACKSPACE,  cmd_fields(8'h00, 32'h0, 4'h0, 5'd0, 7'd0));
        push_cmd(MODE_SET_CURSOR, cmd_fields(8'h00, 32'h0, 4'h0, 5'd0, 7'd0));
        push_cmd(MODE_BACKSPACE,  cmd_fields(8'h00, 32'h0, 4'h0, 5'd0, 7'd0));
        push_cmd(MODE_PUT_CHAR,   cmd_fields(CHAR_NEWLINE, 32'h0, 4'h0, 5'd0, 7'd0));
        push_cmd(MODE_SET_CURSOR, cmd_fields(8'h00, 32'h0, 4'h0, 5'd31, 7'd127));
        push_cmd(MODE_PUT_CHAR,   cmd_fields(8'h5A, 32'h0, 4'h0, 5'd0, 7'd0));
        push_cmd(MODE_PUT_CHAR,   cmd_fields(8'h51, 32'h0, 4'h0, 5'd0, 7'd0));
        push_cmd(MODE_PUT_CHAR,   cmd_fields(CHAR_TAB, 32'h0, 4'h0, 5'd0, 7'd0));
        push_cmd(MODE_PUT_HEX,    cmd_fields(8'h00, 32'hFFFF_FFFF, 4'd3, 5'd0, 7'd0));
        push_cmd(MODE_BACKSPACE,  cmd_fields(8'h00, 32'h0, 4'h0, 5'd0, 7'd0));
        push_cmd(MODE_SET_CURSOR, cmd_fields(8'h00, 32'h0, 4'h0, 5'd24, 7'd77));
        push_cmd(MODE_PUT_HEX,    cmd_fields(8'h00, 32'hFFFF_FFFF, 4'd9, 5'd0, 7'd0));
        push_cmd(MODE_PUT_CHAR,   cmd_fields(CHAR_NEWLINE, 32'h0, 4'h0, 5'd0, 7'd0));
        push_cmd(MODE_PUT_CHAR,   cmd_fields(CHAR_NEWLINE, 32'h0, 4'h0, 5'd0, 7'd0));
        push_cmd(MODE_READ_CELL,  cmd_fields(8'h00, 32'h0, 4'h0, 5'd23, 7'd78));
        push_cmd(MODE_SPARE_6,    cmd_fields(8'hFF, 32'hFFFF_FFFF, 4'hF, 5'h1F, 7'h7F));
        push_cmd(MODE_SPARE_7,    cmd_fields(8'hFF, 32'hFFFF_FFFF, 4'hF, 5'h1F, 7'h7F));
        push_cmd(MODE_CLEAR,      cmd_fields(8'h00, 32'h0, 4'h0, 5'd0, 7'd0));
        push_cmd(MODE_READ_CELL,  cmd_fields(8'h00, 32'h0, 4'h0, 5'd12, 7'd40));
        n_directed = n_sent;
        settle();

        for (ph = 0; ph < 4; ph++) begin
            load_attribute(attr_plan[ph]);
            send_idle_pct  = idle_plan[ph];
            recv_stall_pct = stall_plan[ph];
            if (ph == 0) squeeze_go = 1'b1;
            run_random(RANDOM_PER_PHASE);
            settle();
        end
        repeat (TAIL_CYCLES) @(negedge clk);

        if (pend_cnt != 0) $display("tb: %0d results never arrived", pend_cnt);
        $display("tb: %0d commands (%0d directed), four handshake mixes, %0d attribute loads",
                 n_sent, n_directed, n_loads);
        $display("tb: %0d results checked, %0d with overflow, %0d scrolls, %0d mismatches",
                 checked_cnt, ovf_cnt, scroll_cnt, fail_cnt);
        if (fail_cnt == 0 && pend_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/tcce_pkg.sv
design/tcce_ram.sv
design/tcce_seq.sv
design/text_console_cursor_engine_core.sv
design/tcce_checker.sv
bench/console_check.sv
bench/tb.sv
